// File: rtl/sorted_table_binary_search_assert.svh
// Assertion macros for the sorted table search block.
// Each macro takes a label, a property expression and a message string.
// The clock is aclk; STS_ASSERT is off while aresetn is low, STS_ASSERT_RST checks during reset too.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTH

`define STS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

`define STS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`else

`define STS_ASSERT(label, prop, msg)

`define STS_ASSERT_RST(label, prop, msg)

`endif

`endif

// File: rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 5;
    localparam int INDEX_W         = 4;
    localparam int KEY_W           = 16;
    localparam int TAG_W           = 8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // sequencer steps
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_EMIT
    } step_t;

    // jump conditions
    typedef enum logic [1:0] {
        COND_SEARCH,
        COND_EMPTY,
        COND_HIT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        cond_t cond;     // condition tested in this step
        step_t jump;     // taken when cond is true
        step_t next;     // taken otherwise
        logic  take_in;  // input channel open
        logic  probe;    // range check, midpoint read
        logic  compare;  // compare key, narrow range
        logic  emit;     // load result register
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t uc;
        uc = '0;
        unique case (step)
            ST_IDLE: begin
                uc.cond    = COND_SEARCH;
                uc.jump    = ST_PROBE;
                uc.next    = ST_IDLE;
                uc.take_in = 1'b1;
            end
            ST_PROBE: begin
                uc.cond  = COND_EMPTY;
                uc.jump  = ST_EMIT;
                uc.next  = ST_CMP;
                uc.probe = 1'b1;
            end
            ST_CMP: begin
                uc.cond    = COND_HIT;
                uc.jump    = ST_EMIT;
                uc.next    = ST_PROBE;
                uc.compare = 1'b1;
            end
            ST_EMIT: begin
                uc.cond = COND_OUT_FREE;
                uc.jump = ST_IDLE;
                uc.next = ST_EMIT;
                uc.emit = 1'b1;
            end
            default: begin
                uc = '0;
            end
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sorted_table_binary_search.sv
`default_nettype none

// Channel  | Handshake          | Word
// ---------+--------------------+------------------------------------------------
// s_       | s_valid / s_ready  | s_command, s_entry_index, s_price, s_title_tag
// m_       | m_valid / m_ready  | m_found, m_match_index, m_match_title
// cfg_     | cfg_wr_en          | cfg_wr_data (entry_count)
//
// A load word gives no result. A search runs through P probes (at most
// log2(TABLE_DEPTH)+1): each probe reads the table at the midpoint in the
// probe step (registered read), then compares the key and halves the range in
// the compare step; a miss ends with a final probe step that finds the range
// empty. On a hit or a miss the sequencer then goes to its emit step.
// Reset (aresetn low, synchronous) clears the sequencer, count and m_valid;
// the table itself holds whatever was loaded and is undefined until written.
// The result sits in an output register; the sequencer waits in its emit step
// only while that register still holds an untaken word.

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_wr_en,
    input  wire logic [sts_pkg::COUNT_W-1:0]  cfg_wr_data,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic [sts_pkg::INDEX_W-1:0]  s_entry_index,
    input  wire logic [sts_pkg::KEY_W-1:0]    s_price,
    input  wire logic [sts_pkg::TAG_W-1:0]    s_title_tag,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic [sts_pkg::INDEX_W-1:0]       m_match_index,
    output logic [sts_pkg::TAG_W-1:0]         m_match_title
);

    // table address, range bound and wide compare widths
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int SW    = (CW > sts_pkg::COUNT_W) ? CW : sts_pkg::COUNT_W;
    localparam int AW    = ((IDX_W > sts_pkg::INDEX_W) ? IDX_W : sts_pkg::INDEX_W) + 1;

    // ---------------------------------------------------------------------
    // Sequencer: step counter plus control word from the microcode table
    // ---------------------------------------------------------------------
    sts_pkg::step_t  step_reg, step_next;
    sts_pkg::ucode_t uc;
    logic            cond_true;

    // datapath
    logic [sts_pkg::COUNT_W-1:0] entry_count_reg;
    logic [sts_pkg::KEY_W-1:0]   key_reg;
    logic [CW-1:0]               first_reg;
    logic [CW-1:0]               end_reg;      // one past last
    logic [IDX_W-1:0]            mid_reg;
    logic                        hit_reg;
    logic [sts_pkg::KEY_W-1:0]   rd_key_reg;
    logic [sts_pkg::TAG_W-1:0]   rd_title_reg;

    logic [sts_pkg::KEY_W-1:0]   key_mem   [TABLE_DEPTH];
    logic [sts_pkg::TAG_W-1:0]   title_mem [TABLE_DEPTH];

    logic                        in_fire;
    logic                        search_fire;
    logic                        load_fire;
    logic                        out_free;
    logic                        range_empty;
    logic                        key_eq;
    logic [CW:0]                 mid_sum;
    logic [IDX_W-1:0]            mid_calc;
    logic [SW-1:0]               count_wide;
    logic [CW-1:0]               count_sat;
    logic [AW-1:0]               slot_wide;
    logic                        slot_ok;
    logic [AW-1:0]               mid_wide;

    always_comb begin
        uc = sts_pkg::ucode_rom(step_reg);
    end

    // handshake and condition decode
    assign s_ready     = uc.take_in;
    assign in_fire     = s_valid && s_ready;
    assign search_fire = in_fire && (s_command == sts_pkg::CMD_SEARCH);
    assign load_fire   = in_fire && (s_command == sts_pkg::CMD_LOAD);
    assign out_free    = !m_valid || m_ready;

    // range [first, end): empty when first reaches end
    assign range_empty = (first_reg >= end_reg);
    // floor((first + last) / 2) with last = end - 1; end >= 1 when not empty
    assign mid_sum     = {1'b0, first_reg} + {1'b0, end_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_calc    = mid_sum[IDX_W:1];
    assign key_eq      = (rd_key_reg == key_reg);

    // count saturates at table depth
    assign count_wide  = SW'(entry_count_reg);
    assign count_sat   = (count_wide > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(count_wide);

    // loads beyond the table are dropped
    assign slot_wide   = AW'(s_entry_index);
    assign slot_ok     = (slot_wide < AW'(TABLE_DEPTH));
    assign mid_wide    = AW'(mid_reg);

    always_comb begin
        unique case (uc.cond)
            sts_pkg::COND_SEARCH:   cond_true = search_fire;
            sts_pkg::COND_EMPTY:    cond_true = range_empty;
            sts_pkg::COND_HIT:      cond_true = key_eq;
            sts_pkg::COND_OUT_FREE: cond_true = out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        step_next = cond_true ? uc.jump : uc.next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= sts_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // table memory: one write port, one registered read port at the midpoint
    always_ff @(posedge aclk) begin
        if (load_fire && slot_ok) begin
            key_mem[slot_wide[IDX_W-1:0]]   <= s_price;
            title_mem[slot_wide[IDX_W-1:0]] <= s_title_tag;
        end
        if (uc.probe) begin
            rd_key_reg   <= key_mem[mid_calc];
            rd_title_reg <= title_mem[mid_calc];
        end
    end

    // search registers
    always_ff @(posedge aclk) begin
        if (search_fire) begin
            key_reg   <= s_price;
            first_reg <= '0;
            end_reg   <= count_sat;
        end
        if (uc.probe && !range_empty) begin
            mid_reg <= mid_calc;
        end
        if (uc.compare && !key_eq) begin
            if (key_reg < rd_key_reg) begin
                end_reg <= CW'(mid_reg);
            end else begin
                first_reg <= CW'(mid_reg) + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (search_fire) begin
            hit_reg <= 1'b0;
        end else if (uc.compare && key_eq) begin
            hit_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (uc.emit && out_free) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uc.emit && out_free) begin
            m_found       <= hit_reg;
            m_match_index <= hit_reg ? mid_wide[sts_pkg::INDEX_W-1:0] : '0;
            m_match_title <= hit_reg ? rd_title_reg : '0;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `include "sorted_table_binary_search_assert.svh"

    `STS_ASSERT(a_search_starts_probe,
        search_fire |=> (step_reg == sts_pkg::ST_PROBE),
        "search did not start probing")
    `STS_ASSERT(a_hit_goes_emit,
        (step_reg == sts_pkg::ST_CMP) && key_eq |=> (step_reg == sts_pkg::ST_EMIT) && hit_reg,
        "match not sent to emit")
    `STS_ASSERT(a_result_from_emit,
        $rose(m_valid) |-> $past(step_reg == sts_pkg::ST_EMIT),
        "result without emit step")
    `STS_ASSERT(a_miss_zero,
        m_valid && !m_found |-> (m_match_index == '0) && (m_match_title == '0),
        "miss with nonzero fields")
    `STS_ASSERT_RST(a_reset_idle,
        !aresetn |=> (step_reg == sts_pkg::ST_IDLE) && !m_valid,
        "reset did not idle")

endmodule

`default_nettype wire
